// ===== rtl/core/delayed_trigger_pulse_generator_core_assert.svh =====
// assertion macros used by the trigger delay checker
`ifndef DELAYED_TRIGGER_PULSE_GENERATOR_CORE_ASSERT_SVH
`define DELAYED_TRIGGER_PULSE_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define DTPG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtpg check failed");

// next-cycle implication, sampled on clk, off during reset
`define DTPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtpg check failed");

`endif

// ===== rtl/core/dtpg_pkg.sv =====
// types and constants of the trigger delay one-shot
package dtpg_pkg;

    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int BASE_W    = 20;
    localparam int LEVEL_W   = 14;
    localparam int CHANNEL_W = 4;
    localparam int FACTOR_W  = 13;
    localparam int Q_FRAC    = 12;

    typedef logic [BASE_W-1:0]          base_t;
    typedef logic signed [LEVEL_W-1:0]  level_t;
    typedef logic [CHANNEL_W-1:0]       channel_t;
    typedef logic [FACTOR_W-1:0]        factor_t;

    // register indexes, one 32-bit word each
    typedef enum logic [2:0] {
        REG_UNIT0_DELAY  = 3'd0,
        REG_UNIT0_LENGTH = 3'd1,
        REG_UNIT1_DELAY  = 3'd2,
        REG_UNIT1_LENGTH = 3'd3,
        REG_RISE         = 3'd4,
        REG_FALL         = 3'd5
    } reg_idx_t;

    // Q12 unity and the floor of the length factor
    localparam factor_t Q_ONE     = 13'd4096;
    localparam factor_t LEN_FLOOR = 13'd4;

    // register reset values
    localparam base_t  DELAY_RESET  = 20'd0;
    localparam base_t  LENGTH_RESET = 20'd4800;
    localparam level_t RISE_RESET   = 14'sd410;
    localparam level_t FALL_RESET   = 14'sd0;

endpackage

// ===== rtl/core/dtpg_in_if.sv =====
// input channel: one gate sample for one unit and channel
interface dtpg_in_if
    import dtpg_pkg::*;
();

    logic     valid;
    logic     ready;
    logic     unit;
    channel_t channel;
    level_t   gate_level;
    level_t   delay_cv;
    logic     delay_cv_present;
    level_t   length_cv;
    logic     length_cv_present;

    modport source (
        output valid, unit, channel, gate_level, delay_cv, delay_cv_present,
               length_cv, length_cv_present,
        input  ready
    );

    modport sink (
        input  valid, unit, channel, gate_level, delay_cv, delay_cv_present,
               length_cv, length_cv_present,
        output ready
    );

endinterface

// ===== rtl/core/dtpg_out_if.sv =====
// output channel: pulse state for one unit and channel
interface dtpg_out_if
    import dtpg_pkg::*;
();

    logic     valid;
    logic     ready;
    logic     out_unit;
    channel_t out_channel;
    logic     pulse_high;

    modport source (
        output valid, out_unit, out_channel, pulse_high,
        input  ready
    );

    modport sink (
        input  valid, out_unit, out_channel, pulse_high,
        output ready
    );

endinterface

// ===== rtl/core/delayed_trigger_pulse_generator_core.sv =====
// trigger delay one-shot: two units, schmitt edge, delay counter, pulse counter
// pipeline: input beat into stage 1 (state read), then into the result register (update)
// throughput: one beat per cycle unless stalled; per-slot state sits in a one-write one-read
//   memory with write-to-read bypass, so back-to-back hits on a slot are exact
// reset: rst_n async low; clears registers to defaults, all slot valid bits
//   (unwritten slots read as zero state) and the pipeline valids
module delayed_trigger_pulse_generator_core
    import dtpg_pkg::*;
#(
    parameter int CHANNELS  = 16,
    parameter int TICK_BITS = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    dtpg_in_if.sink           in_ch,
    dtpg_out_if.source        out_ch
);

    localparam int SLOTS    = 2 * CHANNELS;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PROD_W   = BASE_W + FACTOR_W;
    localparam int SCALED_W = PROD_W - Q_FRAC;

    typedef logic [TICK_BITS-1:0] tick_t;
    typedef logic [SLOT_W-1:0]    slot_idx_t;

    typedef struct packed {
        logic  trig;
        logic  pend;
        tick_t delay;
        tick_t pulse;
    } slot_state_t;

    // clamp a control value to a Q12 factor, unity when not connected
    function automatic factor_t clamp_factor(level_t cv, logic present, factor_t lo);
        factor_t f;
        if (!present) begin
            f = Q_ONE;
        end else if (cv < $signed({1'b0, lo})) begin
            f = lo;
        end else if (cv > $signed({1'b0, Q_ONE})) begin
            f = Q_ONE;
        end else begin
            f = factor_t'(cv);
        end
        return f;
    endfunction

    // base * factor >> 12, saturated to the tick counter range
    function automatic tick_t scale_ticks(base_t base, factor_t f);
        logic [PROD_W-1:0]   prod;
        logic [SCALED_W-1:0] scaled;
        logic [63:0]         wide;
        logic [63:0]         tmax;
        prod   = PROD_W'(base) * PROD_W'(f);
        scaled = prod[PROD_W-1:Q_FRAC];
        wide   = 64'(scaled);
        tmax   = (64'd1 << TICK_BITS) - 64'd1;
        return (wide > tmax) ? tick_t'(tmax) : tick_t'(wide);
    endfunction

    // configuration registers
    base_t  unit0_delay_reg;
    base_t  unit0_length_reg;
    base_t  unit1_delay_reg;
    base_t  unit1_length_reg;
    level_t rise_reg;
    level_t fall_reg;

    logic     cfg_write;
    reg_idx_t cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit0_delay_reg  <= DELAY_RESET;
            unit0_length_reg <= LENGTH_RESET;
            unit1_delay_reg  <= DELAY_RESET;
            unit1_length_reg <= LENGTH_RESET;
            rise_reg         <= RISE_RESET;
            fall_reg         <= FALL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_UNIT0_DELAY:  unit0_delay_reg  <= pwdata[BASE_W-1:0];
                REG_UNIT0_LENGTH: unit0_length_reg <= pwdata[BASE_W-1:0];
                REG_UNIT1_DELAY:  unit1_delay_reg  <= pwdata[BASE_W-1:0];
                REG_UNIT1_LENGTH: unit1_length_reg <= pwdata[BASE_W-1:0];
                REG_RISE:         rise_reg         <= level_t'(pwdata[LEVEL_W-1:0]);
                REG_FALL:         fall_reg         <= level_t'(pwdata[LEVEL_W-1:0]);
                default:          ;
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case (cfg_idx)
            REG_UNIT0_DELAY:  prdata = DATA_W'(unit0_delay_reg);
            REG_UNIT0_LENGTH: prdata = DATA_W'(unit0_length_reg);
            REG_UNIT1_DELAY:  prdata = DATA_W'(unit1_delay_reg);
            REG_UNIT1_LENGTH: prdata = DATA_W'(unit1_length_reg);
            REG_RISE:         prdata = DATA_W'(rise_reg);
            REG_FALL:         prdata = DATA_W'(fall_reg);
            default:          prdata = '0;
        endcase
    end

    // pipeline handshake
    logic s1_valid_reg;
    logic res_valid_reg;
    logic s1_move;
    logic in_accept;

    assign s1_move     = s1_valid_reg && (!res_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_move;
    assign in_accept   = in_ch.valid && in_ch.ready;

    // input side: slot index, range check and scaled times
    slot_idx_t in_slot;
    logic      in_range;
    tick_t     in_dt;
    tick_t     in_lt;

    always_comb
    begin
        in_range = 32'(in_ch.channel) < CHANNELS;
        in_slot  = SLOT_W'(32'(in_ch.unit) * CHANNELS + 32'(in_ch.channel));
        in_dt    = scale_ticks(in_ch.unit ? unit1_delay_reg : unit0_delay_reg,
                               clamp_factor(in_ch.delay_cv, in_ch.delay_cv_present,
                                            factor_t'(0)));
        in_lt    = scale_ticks(in_ch.unit ? unit1_length_reg : unit0_length_reg,
                               clamp_factor(in_ch.length_cv, in_ch.length_cv_present,
                                            LEN_FLOOR));
    end

    // stage 1 payload
    logic        s1_unit_reg;
    channel_t    s1_channel_reg;
    level_t      s1_gate_reg;
    tick_t       s1_dt_reg;
    tick_t       s1_lt_reg;
    logic        s1_in_range_reg;
    slot_idx_t   s1_slot_reg;
    slot_state_t s1_word_reg;
    logic        s1_word_valid_reg;

    // per-slot state memory and valid bits
    slot_state_t      state_mem [SLOTS];
    logic [SLOTS-1:0] slot_valid_reg;

    logic        wr_en;
    slot_state_t wr_word;
    logic        wr_hit;
    logic        pulse_next;

    assign wr_en  = s1_move && s1_in_range_reg;
    assign wr_hit = wr_en && (s1_slot_reg == in_slot);

    // memory write, registered read with bypass of the same-edge write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            state_mem[s1_slot_reg] <= wr_word;
        end
        if (in_accept)
        begin
            s1_word_reg       <= wr_hit ? wr_word : state_mem[in_slot];
            s1_word_valid_reg <= wr_hit || slot_valid_reg[in_slot];
            s1_unit_reg       <= in_ch.unit;
            s1_channel_reg    <= in_ch.channel;
            s1_gate_reg       <= in_ch.gate_level;
            s1_dt_reg         <= in_dt;
            s1_lt_reg         <= in_lt;
            s1_in_range_reg   <= in_range;
            s1_slot_reg       <= in_slot;
        end
    end

    // slot valid bits, a slot never written reads as zero state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            slot_valid_reg[s1_slot_reg] <= 1'b1;
        end
    end

    // schmitt edge, delay and pulse counter update
    always_comb
    begin
        slot_state_t cur;
        logic        edge_hit;
        cur      = s1_word_valid_reg ? s1_word_reg : '0;
        edge_hit = 1'b0;
        if (cur.trig)
        begin
            if (s1_gate_reg <= fall_reg)
            begin
                cur.trig = 1'b0;
            end
        end
        else if (s1_gate_reg >= rise_reg)
        begin
            cur.trig = 1'b1;
            edge_hit = 1'b1;
        end
        if (edge_hit)
        begin
            if (s1_dt_reg > cur.delay)
            begin
                cur.delay = s1_dt_reg;
            end
            cur.pend = 1'b1;
        end
        if (cur.delay != '0)
        begin
            cur.delay = cur.delay - tick_t'(1);
        end
        else if (cur.pend)
        begin
            if (s1_lt_reg > cur.pulse)
            begin
                cur.pulse = s1_lt_reg;
            end
            cur.pend = 1'b0;
        end
        pulse_next = 1'b0;
        if (cur.pulse != '0)
        begin
            cur.pulse  = cur.pulse - tick_t'(1);
            pulse_next = s1_in_range_reg;
        end
        wr_word = cur;
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    logic     res_unit_reg;
    channel_t res_channel_reg;
    logic     res_pulse_reg;

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            res_unit_reg    <= s1_unit_reg;
            res_channel_reg <= s1_channel_reg;
            res_pulse_reg   <= pulse_next;
        end
    end

    assign out_ch.valid       = res_valid_reg;
    assign out_ch.out_unit    = res_unit_reg;
    assign out_ch.out_channel = res_channel_reg;
    assign out_ch.pulse_high  = res_pulse_reg;

endmodule

// ===== rtl/core/dtpg_checker.sv =====
// port-level checker for the trigger delay one-shot, with its bind
`include "delayed_trigger_pulse_generator_core_assert.svh"

module dtpg_checker
    import dtpg_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input logic     out_unit,
    input channel_t out_channel,
    input logic     out_pulse_high
);

    // result payload as one vector
    logic [CHANNEL_W+1:0] out_payload;

    assign out_payload = {out_unit, out_channel, out_pulse_high};

    // a stalled result beat holds its payload
    `DTPG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

    // input back-pressure only comes from a full, stalled output
    `DTPG_ASSERT_NOW(a_stall_source, !in_ready, out_valid && !out_ready)

    // an accepted beat shows up as a result beat after stage 1 when the sink keeps up
    `DTPG_ASSERT_NEXT(a_latency, in_valid && in_ready ##1 out_ready, out_valid)

    // a channel beyond the unit never pulses
    `DTPG_ASSERT_NOW(a_range_quiet, out_valid && (32'(out_channel) >= CHANNELS), !out_pulse_high)

endmodule

bind delayed_trigger_pulse_generator_core dtpg_checker #(
    .CHANNELS (CHANNELS)
) u_dtpg_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_unit       (out_ch.out_unit),
    .out_channel    (out_ch.out_channel),
    .out_pulse_high (out_ch.pulse_high)
);

// ===== bench/tb_delayed_trigger_pulse_generator_core.sv =====
// testbench of the trigger delay one-shot: directed and random gate samples checked per beat
`timescale 1ns / 1ps

module tb_delayed_trigger_pulse_generator_core;
    import dtpg_pkg::*;

    localparam int     CHANNELS   = 16;
    localparam int     TICK_BITS  = 20;
    localparam longint TICK_MAX   = (longint'(1) << TICK_BITS) - 1;
    localparam int     FULL_SCALE = Q_ONE;
    localparam int     LEN_MIN    = LEN_FLOOR;
    localparam int     SLOT_COUNT = 2 * CHANNELS;

    typedef struct {
        logic     unit;
        channel_t channel;
        level_t   gate_level;
        level_t   delay_cv;
        logic     delay_cv_present;
        level_t   length_cv;
        logic     length_cv_present;
    } gate_sample_t;

    typedef struct {
        logic     unit;
        channel_t channel;
        logic     pulse_high;
    } pulse_beat_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    dtpg_in_if  in_ch ();
    dtpg_out_if out_ch ();

    delayed_trigger_pulse_generator_core #(
        .CHANNELS  (CHANNELS),
        .TICK_BITS (TICK_BITS)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // register shadow
    longint delay_base[2]  = '{DELAY_RESET, DELAY_RESET};
    longint length_base[2] = '{LENGTH_RESET, LENGTH_RESET};
    int     rise_thr       = RISE_RESET;
    int     fall_thr       = FALL_RESET;

    // per-slot state of the one-shot
    bit     trig_high[SLOT_COUNT];
    bit     armed[SLOT_COUNT];
    longint delay_left[SLOT_COUNT];
    longint pulse_left[SLOT_COUNT];

    pulse_beat_t predicted_pulses[$];
    int          errors;

    // traffic shaping
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_cycles;
    int hot_slot[4] = '{0, 1, 16, 17};
    bit want_high[SLOT_COUNT];

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clamp_factor(input level_t cv, input int floor_val);
        int v;
        v = cv;
        if (v < floor_val)
            return floor_val;
        if (v > FULL_SCALE)
            return FULL_SCALE;
        return v;
    endfunction

    function automatic longint scale_ticks(input longint base, input int fac);
        longint t;
        t = (base * fac) >> Q_FRAC;
        return (t > TICK_MAX) ? TICK_MAX : t;
    endfunction

    // schmitt edge, delay countdown, pulse countdown for one sample
    function automatic pulse_beat_t predict_pulse(input gate_sample_t s);
        pulse_beat_t r;
        int          slot;
        int          dfac;
        int          lfac;
        longint      dly_ticks;
        longint      len_ticks;
        bit          fired;
        r.unit       = s.unit;
        r.channel    = s.channel;
        r.pulse_high = 1'b0;
        slot = int'({s.unit, s.channel});
        dfac = s.delay_cv_present ? clamp_factor(s.delay_cv, 0) : FULL_SCALE;
        lfac = s.length_cv_present ? clamp_factor(s.length_cv, LEN_MIN) : FULL_SCALE;
        dly_ticks = scale_ticks(delay_base[s.unit], dfac);
        len_ticks = scale_ticks(length_base[s.unit], lfac);

        fired = 1'b0;
        if (trig_high[slot])
        begin
            if (int'(s.gate_level) <= fall_thr)
                trig_high[slot] = 1'b0;
        end
        else if (int'(s.gate_level) >= rise_thr)
        begin
            trig_high[slot] = 1'b1;
            fired = 1'b1;
        end

        // retrigger keeps the longer remaining delay
        if (fired)
        begin
            if (dly_ticks > delay_left[slot])
                delay_left[slot] = dly_ticks;
            armed[slot] = 1'b1;
        end

        if (delay_left[slot] > 0)
            delay_left[slot]--;
        else if (armed[slot])
        begin
            if (len_ticks > pulse_left[slot])
                pulse_left[slot] = len_ticks;
            armed[slot] = 1'b0;
        end

        if (pulse_left[slot] > 0)
        begin
            pulse_left[slot]--;
            r.pulse_high = 1'b1;
        end
        return r;
    endfunction

    // predict on input beats, compare on output beats
    always @(posedge clk)
    begin
        gate_sample_t s;
        pulse_beat_t  want;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                s.unit              = in_ch.unit;
                s.channel           = in_ch.channel;
                s.gate_level        = in_ch.gate_level;
                s.delay_cv          = in_ch.delay_cv;
                s.delay_cv_present  = in_ch.delay_cv_present;
                s.length_cv         = in_ch.length_cv;
                s.length_cv_present = in_ch.length_cv_present;
                predicted_pulses.push_back(predict_pulse(s));
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (predicted_pulses.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected beat unit %0d channel %0d pulse %0d",
                                 $realtime, out_ch.out_unit, out_ch.out_channel,
                                 out_ch.pulse_high);
                end
                else
                begin
                    want = predicted_pulses.pop_front();
                    if (out_ch.out_unit !== want.unit || out_ch.out_channel !== want.channel
                        || out_ch.pulse_high !== want.pulse_high)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch exp unit %0d ch %0d pulse %0d, got %0d %0d %0d",
                                     $realtime, want.unit, want.channel, want.pulse_high,
                                     out_ch.out_unit, out_ch.out_channel, out_ch.pulse_high);
                    end
                end
            end
        end
    end

    // receiver: random stalls plus a counted long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_cycles--;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("tb_delayed_trigger_pulse_generator_core NOT OK");
        $finish;
    end

    function automatic int pick_between(input int lo, input int hi);
        if (hi < lo)
            return hi + int'($urandom_range(lo - hi));
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic gate_sample_t mk_sample(input bit u, input int ch, input int gate,
                                               input int dcv, input bit dp,
                                               input int lcv, input bit lp);
        gate_sample_t s;
        s.unit              = u;
        s.channel           = channel_t'(ch);
        s.gate_level        = level_t'(gate);
        s.delay_cv          = level_t'(dcv);
        s.delay_cv_present  = dp;
        s.length_cv         = level_t'(lcv);
        s.length_cv_present = lp;
        return s;
    endfunction

    function automatic level_t random_cv();
        int pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 60)
            v = $urandom_range(FULL_SCALE);
        else if (pick < 75)
        begin
            case ($urandom_range(3))
                0: v = 0;
                1: v = FULL_SCALE;
                2: v = LEN_MIN;
                default: v = 1;
            endcase
        end
        else
            v = $urandom;
        return level_t'(v);
    endfunction

    // mostly clean high/low toggles on a few busy slots, some noise
    function automatic gate_sample_t random_sample();
        gate_sample_t s;
        int           slot;
        int           pick;
        slot = ($urandom_range(99) < 75) ? hot_slot[$urandom_range(3)]
                                         : int'($urandom_range(SLOT_COUNT - 1));
        s.unit    = slot[4];
        s.channel = channel_t'(slot[3:0]);
        pick = $urandom_range(99);
        if (pick < 80)
        begin
            if ($urandom_range(99) < 35)
                want_high[slot] = !want_high[slot];
            s.gate_level = want_high[slot] ? level_t'(pick_between(rise_thr, 8191))
                                           : level_t'(pick_between(-8192, fall_thr));
        end
        else if (pick < 90)
            s.gate_level = level_t'(pick_between(fall_thr, rise_thr));
        else
            s.gate_level = level_t'($urandom);
        s.delay_cv_present  = $urandom_range(1);
        s.delay_cv          = random_cv();
        s.length_cv_present = $urandom_range(1);
        s.length_cv         = random_cv();
        return s;
    endfunction

    // one beat on the input channel; entered and left at a falling edge
    task automatic send_sample(input gate_sample_t s);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        in_ch.valid             <= 1'b1;
        in_ch.unit              <= s.unit;
        in_ch.channel           <= s.channel;
        in_ch.gate_level        <= s.gate_level;
        in_ch.delay_cv          <= s.delay_cv;
        in_ch.delay_cv_present  <= s.delay_cv_present;
        in_ch.length_cv         <= s.length_cv;
        in_ch.length_cv_present <= s.length_cv_present;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop sending and wait for every predicted beat
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (predicted_pulses.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        level_t thr;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        thr = value[LEVEL_W-1:0];
        case (idx)
            REG_UNIT0_DELAY:  delay_base[0]  = value[BASE_W-1:0];
            REG_UNIT0_LENGTH: length_base[0] = value[BASE_W-1:0];
            REG_UNIT1_DELAY:  delay_base[1]  = value[BASE_W-1:0];
            REG_UNIT1_LENGTH: length_base[1] = value[BASE_W-1:0];
            REG_RISE:         rise_thr       = thr;
            REG_FALL:         fall_thr       = thr;
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(input int d0, input int l0, input int d1, input int l1,
                              input int rise, input int fall);
        write_reg(REG_UNIT0_DELAY, DATA_W'(d0));
        write_reg(REG_UNIT0_LENGTH, DATA_W'(l0));
        write_reg(REG_UNIT1_DELAY, DATA_W'(d1));
        write_reg(REG_UNIT1_LENGTH, DATA_W'(l1));
        write_reg(REG_RISE, DATA_W'(rise));
        write_reg(REG_FALL, DATA_W'(fall));
    endtask

    // short bases so pulses start and end within a phase
    task automatic random_config();
        int rise;
        int fall;
        int i;
        case ($urandom_range(3))
            0:
            begin
                rise = RISE_RESET;
                fall = FALL_RESET;
            end
            1:
            begin
                rise = pick_between(-2000, 4000);
                fall = rise - 1 - int'($urandom_range(1500));
            end
            2:
            begin
                // fall above rise
                fall = pick_between(-1000, 1000);
                rise = fall - int'($urandom_range(1, 500));
            end
            default:
            begin
                rise = pick_between(-8192, 8191);
                fall = pick_between(-8192, 8191);
            end
        endcase
        for (i = 0; i < 4; i++)
            hot_slot[i] = $urandom_range(SLOT_COUNT - 1);
        set_config(($urandom_range(99) < 15) ? 0 : int'($urandom_range(1, 16)),
                   ($urandom_range(99) < 5) ? 0 : int'($urandom_range(1, 24)),
                   ($urandom_range(99) < 15) ? 0 : int'($urandom_range(1, 16)),
                   ($urandom_range(99) < 5) ? 0 : int'($urandom_range(1, 24)),
                   rise, fall);
    endtask

    // reset values: zero delay starts the pulse on the edge sample
    task automatic test_zero_delay();
        send_sample(mk_sample(0, 0, 410, 0, 0, 0, 0));
        send_sample(mk_sample(0, 0, 0, 0, 0, 0, 0));
        send_sample(mk_sample(1, 15, 8191, 0, 0, 0, 0));
        wait_idle();
    endtask

    // field extremes, control clamps and the length floor
    task automatic test_field_extremes();
        int i;
        set_config(3, 5, 0, 7, 410, 0);
        send_sample(mk_sample(0, 1, -8192, -8192, 1, -8192, 1));
        send_sample(mk_sample(0, 1, 8191, -8192, 1, -8192, 1));
        send_sample(mk_sample(1, 15, 8191, 0, 0, 4096, 1));
        send_sample(mk_sample(0, 2, 8191, 8191, 1, 8191, 1));
        for (i = 0; i < 4; i++)
            send_sample(mk_sample(0, 2, 409, 0, 0, 0, 0));
        wait_idle();
    endtask

    // retrigger keeps the longer delay and the longer pulse
    task automatic test_retrigger();
        set_config(8, 6, 0, 6, 410, 0);
        send_sample(mk_sample(0, 3, 1000, 4096, 1, 4096, 1));
        send_sample(mk_sample(0, 3, -1, 0, 0, 0, 0));
        send_sample(mk_sample(0, 3, 1000, 1024, 1, 0, 0));
        send_sample(mk_sample(1, 3, 1000, 0, 0, 4096, 1));
        send_sample(mk_sample(1, 3, -1, 0, 0, 0, 0));
        send_sample(mk_sample(1, 3, 1000, 0, 0, 2048, 1));
        send_sample(mk_sample(1, 3, 1000, 0, 0, 0, 0));
        wait_idle();
    endtask

    // zero length produces no pulse
    task automatic test_zero_length();
        set_config(2, 0, 0, 0, 410, 0);
        send_sample(mk_sample(0, 4, 8191, 0, 0, 0, 0));
        send_sample(mk_sample(0, 4, 8191, 0, 0, 0, 0));
        send_sample(mk_sample(0, 4, 8191, 0, 0, 0, 0));
        send_sample(mk_sample(1, 4, 8191, 0, 0, 0, 0));
        wait_idle();
    endtask

    // fall threshold above rise threshold
    task automatic test_crossed_thresholds();
        set_config(0, 3, 0, 3, -100, 200);
        send_sample(mk_sample(0, 6, 0, 0, 0, 0, 0));
        send_sample(mk_sample(0, 6, 150, 0, 0, 0, 0));
        send_sample(mk_sample(0, 6, -50, 0, 0, 0, 0));
        send_sample(mk_sample(0, 6, 8191, 0, 0, 0, 0));
        wait_idle();
    endtask

    // register extremes
    task automatic test_register_extremes();
        set_config(1048575, 1048575, 1048575, 1, 8191, -8192);
        send_sample(mk_sample(0, 5, 8190, 0, 0, 0, 0));
        send_sample(mk_sample(0, 5, 8191, 0, 1, 0, 1));
        send_sample(mk_sample(1, 5, 8191, 4096, 1, 4096, 1));
        wait_idle();
        set_config(0, 1, 0, 1, -8192, 8191);
        send_sample(mk_sample(0, 7, -8192, 0, 0, 0, 0));
        send_sample(mk_sample(0, 7, -8192, 0, 0, 0, 0));
        send_sample(mk_sample(0, 7, 5, 0, 0, 0, 0));
        wait_idle();
    endtask

    // random traffic under two register settings
    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        int phase;
        int i;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (phase = 0; phase < 2; phase++)
        begin
            random_config();
            for (i = 0; i < count / 2; i++)
                send_sample(random_sample());
            wait_idle();
        end
    endtask

    // long receiver hold-off while the sender keeps offering beats
    task automatic test_backpressure();
        int i;
        tx_idle_pct = 0;
        rx_idle_pct = 20;
        random_config();
        hold_cycles = 400;
        for (i = 0; i < 60; i++)
            send_sample(random_sample());
        wait_idle();
    endtask

    // sender pauses until the block has drained
    task automatic test_sender_pause();
        int i;
        tx_idle_pct = 10;
        rx_idle_pct = 30;
        for (i = 0; i < 25; i++)
            send_sample(random_sample());
        wait_idle();
        for (i = 0; i < 25; i++)
            send_sample(random_sample());
        wait_idle();
    endtask

    initial
    begin
        int n;
        rst_n                   = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        in_ch.valid             = 1'b0;
        in_ch.unit              = 1'b0;
        in_ch.channel           = '0;
        in_ch.gate_level        = '0;
        in_ch.delay_cv          = '0;
        in_ch.delay_cv_present  = 1'b0;
        in_ch.length_cv         = '0;
        in_ch.length_cv_present = 1'b0;
        out_ch.ready            = 1'b0;
        errors                  = 0;
        tx_idle_pct             = 0;
        rx_idle_pct             = 0;
        hold_cycles             = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_zero_delay();
        test_field_extremes();
        test_retrigger();
        test_zero_length();
        test_crossed_thresholds();
        test_register_extremes();
        test_random_traffic(36, 61, 530);
        test_random_traffic(61, 36, 530);
        test_random_traffic(0, 0, 530);
        test_backpressure();
        test_sender_pause();

        // final drain with a bound
        rx_idle_pct = 0;
        for (n = 0; n < 100000 && predicted_pulses.size() != 0; n++)
            @(negedge clk);
        repeat (8) @(negedge clk);
        errors += predicted_pulses.size();

        if (errors == 0)
            $display("tb_delayed_trigger_pulse_generator_core OK");
        else
            $display("tb_delayed_trigger_pulse_generator_core NOT OK");
        $finish;
    end

endmodule

// ===== delayed_trigger_pulse_generator_core.f =====
+incdir+rtl/core
rtl/core/dtpg_pkg.sv
rtl/core/dtpg_in_if.sv
rtl/core/dtpg_out_if.sv
rtl/core/delayed_trigger_pulse_generator_core.sv
rtl/core/dtpg_checker.sv
bench/tb_delayed_trigger_pulse_generator_core.sv
